### sv/fkin_pkg.sv
// Shared types, constants and the rounding Q30 multiply for the six-joint
// forward kinematics block. No dependencies.
package fkin_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int ANG_W   = 16;   // joint angle port width
  localparam int LEN_W   = 8;    // geometry register width
  localparam int POS_W   = 24;   // position port width
  localparam int TRIG_W  = 32;   // signed Q2.30 trig value
  localparam int VAL_W   = 35;   // signed Q30 intermediate
  localparam int ACC_W   = 33;   // Taylor partial sum
  localparam int PROD_W  = 44;   // length times Q30 value
  localparam int SUM_W   = 47;   // sum of five such products

  localparam int TAYLOR_STEPS = 9;
  localparam int LANE_LAT     = 3 + 3 * TAYLOR_STEPS + 1;
  localparam int MERGE_LAT    = 6;

  localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'h6487_ED51;

  typedef enum logic [2:0] {
    CFG_SHOULDER_OFFSET  = 3'd0,
    CFG_UPPER_ARM_LENGTH = 3'd1,
    CFG_FOREARM_OFFSET   = 3'd2,
    CFG_FOREARM_LENGTH   = 3'd3,
    CFG_TOOL_LENGTH      = 3'd4,
    CFG_BASE_HEIGHT      = 3'd5
  } cfg_idx_t;

  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // one Taylor step's worth of lane state
  typedef struct packed {
    logic [1:0]  quad;
    logic [31:0] x2;
    logic [31:0] ts;
    logic [31:0] tc;
    acc_t        s;
    acc_t        c;
  } step_t;

  typedef struct packed {
    trig_t sn;
    trig_t cs;
  } sincos_t;

  typedef struct packed {
    logic [LEN_W-1:0] a;
    logic [LEN_W-1:0] l;
    logic [LEN_W-1:0] d;
    logic [LEN_W-1:0] f;
    logic [LEN_W-1:0] t;
    logic [LEN_W-1:0] h;
  } geom_t;

  // Q30 product, rounded to nearest with ties upward
  function automatic val_t fmul(input trig_t a, input val_t b);
    logic signed [66:0] p;
    p = 67'(a) * 67'(b) + (67'sd1 <<< 29);
    return p[64:30];
  endfunction

endpackage

### sv/six_joint_forward_kinematics.sv
// Top level of the six-joint forward kinematics block: geometry registers,
// six sine/cosine lanes, merge stage and valid pipeline. Uses fkin_pkg.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------
//   in_     | in        | in_valid / in_stall  | in_angle_one .. in_angle_six
//   out_    | out       | out_valid / out_stall| out_pos_x, out_pos_y, out_pos_z
//   cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One beat is accepted every clock while in_stall is low; each result passes
// through the nine three-stage Taylor steps of its lane and then the merge stage.
// The whole pipeline, output register included, advances together; it
// freezes only while a result sits in the output register and out_stall is
// high, so in_stall is exactly that condition.
// Reset clears the valid pipeline and loads the default arm geometry.
// cfg_ready is always high; a write to an unknown index is dropped.
module six_joint_forward_kinematics import fkin_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [ANG_W-1:0]        in_angle_one,
  input  logic [ANG_W-1:0]        in_angle_two,
  input  logic [ANG_W-1:0]        in_angle_three,
  input  logic [ANG_W-1:0]        in_angle_four,
  input  logic [ANG_W-1:0]        in_angle_five,
  input  logic [ANG_W-1:0]        in_angle_six,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [POS_W-1:0] out_pos_x,
  output logic signed [POS_W-1:0] out_pos_y,
  output logic signed [POS_W-1:0] out_pos_z,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [LEN_W-1:0]        cfg_data
);

  localparam int LAT = LANE_LAT + MERGE_LAT;

  geom_t            geom_r;
  logic [LAT-1:0]   vld_r;
  logic             en;
  logic [ANG_W-1:0] angle_23;
  sincos_t          sc [0:5];

  // hold everything while the finished beat waits
  assign en        = !(vld_r[LAT-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld_r[LAT-1];
  assign cfg_ready = 1'b1;

  // shoulder plus elbow wraps modulo a turn
  assign angle_23 = in_angle_two + in_angle_three;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      geom_r <= '{a: LEN_W'(2), l: LEN_W'(14), d: LEN_W'(3),
                  f: LEN_W'(15), t: LEN_W'(3), h: LEN_W'(10)};
    end else begin
      if (en) vld_r <= {vld_r[LAT-2:0], in_valid};
      if (cfg_valid) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SHOULDER_OFFSET:  geom_r.a <= cfg_data;
          CFG_UPPER_ARM_LENGTH: geom_r.l <= cfg_data;
          CFG_FOREARM_OFFSET:   geom_r.d <= cfg_data;
          CFG_FOREARM_LENGTH:   geom_r.f <= cfg_data;
          CFG_TOOL_LENGTH:      geom_r.t <= cfg_data;
          CFG_BASE_HEIGHT:      geom_r.h <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // six lanes: base, shoulder, shoulder+elbow, wrist roll, wrist pitch, tool roll
  fkin_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_lane1 (
    .clk(clk), .en(en), .angle(in_angle_one),  .sc(sc[0]));
  fkin_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_lane2 (
    .clk(clk), .en(en), .angle(in_angle_two),  .sc(sc[1]));
  fkin_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_lane23 (
    .clk(clk), .en(en), .angle(angle_23),      .sc(sc[2]));
  fkin_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_lane4 (
    .clk(clk), .en(en), .angle(in_angle_four), .sc(sc[3]));
  fkin_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_lane5 (
    .clk(clk), .en(en), .angle(in_angle_five), .sc(sc[4]));
  fkin_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_lane6 (
    .clk(clk), .en(en), .angle(in_angle_six),  .sc(sc[5]));

  fkin_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk   (clk),
    .en    (en),
    .sc1   (sc[0]),
    .sc2   (sc[1]),
    .sc23  (sc[2]),
    .sc4   (sc[3]),
    .sc5   (sc[4]),
    .sc6   (sc[5]),
    .geom  (geom_r),
    .pos_x (out_pos_x),
    .pos_y (out_pos_y),
    .pos_z (out_pos_z)
  );

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("valid pipeline moved while stalled");

  a_rise_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(en))
    else $error("result appeared without pipeline advance");

  a_lane_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LANE_LAT-1] |-> (sc[0].sn <= trig_t'(ONE_Q30)) && (sc[0].sn >= -trig_t'(ONE_Q30)))
    else $error("lane sine outside unit range");

endmodule

### sv/fkin_step.sv
// One Taylor term for sine and cosine: multiply by x^2, then exact floor
// division by a constant via reciprocal and one correction. Uses fkin_pkg.
module fkin_step import fkin_pkg::*; #(
  parameter int K = 1
) (
  input  logic  clk,
  input  logic  en,
  input  step_t d_in,
  output step_t d_out
);

  localparam int          DS  = (2 * K) * (2 * K + 1);
  localparam int          DC  = (2 * K - 1) * (2 * K);
  localparam logic [63:0] MS  = (64'd1 << 32) / DS;
  localparam logic [63:0] MC  = (64'd1 << 32) / DC;

  step_t       a_r, b_r, c_r;
  logic [31:0] ns_r, nc_r, ns2_r, nc2_r, qs_r, qc_r;
  logic [63:0] ps, pc, rs, rc;
  logic [41:0] rems, remc;
  logic [31:0] qs_fix, qc_fix;
  step_t       c_nxt;

  assign ps = 64'(d_in.ts) * 64'(d_in.x2);
  assign pc = 64'(d_in.tc) * 64'(d_in.x2);
  assign rs = 64'(ns_r) * 64'(MS[31:0]);
  assign rc = 64'(nc_r) * 64'(MC[31:0]);

  always_comb begin
    rems   = 42'(ns2_r) - 42'(qs_r) * 42'(DS);
    remc   = 42'(nc2_r) - 42'(qc_r) * 42'(DC);
    qs_fix = qs_r + 32'(rems >= 42'(DS));
    qc_fix = qc_r + 32'(remc >= 42'(DC));
    c_nxt    = b_r;
    c_nxt.ts = qs_fix;
    c_nxt.tc = qc_fix;
    if (K % 2 == 1) begin
      c_nxt.s = b_r.s - acc_t'({1'b0, qs_fix});
      c_nxt.c = b_r.c - acc_t'({1'b0, qc_fix});
    end else begin
      c_nxt.s = b_r.s + acc_t'({1'b0, qs_fix});
      c_nxt.c = b_r.c + acc_t'({1'b0, qc_fix});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r   <= d_in;
      ns_r  <= ps[61:30];
      nc_r  <= pc[61:30];
      b_r   <= a_r;
      ns2_r <= ns_r;
      nc2_r <= nc_r;
      qs_r  <= rs[63:32];
      qc_r  <= rc[63:32];
      c_r   <= c_nxt;
    end
  end

  assign d_out = c_r;

endmodule

### sv/fkin_sincos.sv
// Sine and cosine lane: binary angle to Q30 radians, Taylor series in a
// chain of fkin_step stages, clamp and quadrant fold. Uses fkin_pkg.
module fkin_sincos import fkin_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic             clk,
  input  logic             en,
  input  logic [ANG_W-1:0] angle,
  output sincos_t          sc
);

  localparam logic [31:0] MASK = (32'd1 << ANGLE_BITS) - 32'd1;

  logic [31:0] a32;
  logic [1:0]  quad0_r, quad1_r;
  logic [29:0] r_r;
  logic [31:0] x_r;
  logic [60:0] p1;
  logic [63:0] p2;
  step_t       chain [0:TAYLOR_STEPS];
  step_t       init_nxt, init_r;
  trig_t       s_cl, c_cl;
  sincos_t     sc_nxt, sc_r;

  assign a32 = 32'((32'(angle) & MASK) << (32 - ANGLE_BITS));
  assign p1  = 61'(r_r) * 61'(HALF_PI_Q30);
  assign p2  = 64'(x_r) * 64'(x_r);

  always_comb begin
    init_nxt.quad = quad1_r;
    init_nxt.x2   = p2[61:30];
    init_nxt.ts   = x_r;
    init_nxt.tc   = ONE_Q30;
    init_nxt.s    = acc_t'({1'b0, x_r});
    init_nxt.c    = acc_t'({1'b0, ONE_Q30});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quad0_r <= a32[31:30];
      r_r     <= a32[29:0];
      quad1_r <= quad0_r;
      x_r     <= {1'b0, p1[60:30]};
      init_r  <= init_nxt;
      sc_r    <= sc_nxt;
    end
  end

  assign chain[0] = init_r;

  for (genvar k = 1; k <= TAYLOR_STEPS; k++) begin : g_term
    fkin_step #(.K(k)) u_step (
      .clk   (clk),
      .en    (en),
      .d_in  (chain[k-1]),
      .d_out (chain[k])
    );
  end

  always_comb begin
    if (chain[TAYLOR_STEPS].s < 0)                  s_cl = '0;
    else if (chain[TAYLOR_STEPS].s > acc_t'(ONE_Q30)) s_cl = trig_t'(ONE_Q30);
    else                                            s_cl = trig_t'(chain[TAYLOR_STEPS].s);
    if (chain[TAYLOR_STEPS].c < 0)                  c_cl = '0;
    else if (chain[TAYLOR_STEPS].c > acc_t'(ONE_Q30)) c_cl = trig_t'(ONE_Q30);
    else                                            c_cl = trig_t'(chain[TAYLOR_STEPS].c);
    case (chain[TAYLOR_STEPS].quad)
      2'd0:    begin sc_nxt.sn = s_cl;  sc_nxt.cs = c_cl;  end
      2'd1:    begin sc_nxt.sn = c_cl;  sc_nxt.cs = -s_cl; end
      2'd2:    begin sc_nxt.sn = -s_cl; sc_nxt.cs = -c_cl; end
      default: begin sc_nxt.sn = -c_cl; sc_nxt.cs = s_cl;  end
    endcase
  end

  assign sc = sc_r;

endmodule

### sv/fkin_merge.sv
// Merge stage: combines the six lanes' sine/cosine pairs into the tool tip
// position through four product levels, length scaling and output rounding.
module fkin_merge import fkin_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  sincos_t                 sc1,
  input  sincos_t                 sc2,
  input  sincos_t                 sc23,
  input  sincos_t                 sc4,
  input  sincos_t                 sc5,
  input  sincos_t                 sc6,
  input  geom_t                   geom,
  output logic signed [POS_W-1:0] pos_x,
  output logic signed [POS_W-1:0] pos_y,
  output logic signed [POS_W-1:0] pos_z
);

  localparam int SH = 30 - FRAC_BITS;

  typedef struct packed {
    trig_t s1, c1, s2, c2, q, p, s4, c4, s5, c5, s6, c6;
  } pose_t;

  typedef struct packed {
    val_t a, b, c, d, c1c2, s1c2;
  } arm_t;

  pose_t pose, pm1_r, pm2_r, pm3_r, pm4_r;
  arm_t  am1_r, am2_r, am3_r, am4_r;

  val_t c4s1_r, s1s4_r, c1c4_r, c1s4_r, s4s6_r, c4c5_r, s5p_r;
  val_t s4a_r, c4a_r, s5c_r, s4b_r, c4b_r, s5d_r, s4s6q_r, c4c5q_r;
  val_t c4s1m2_r, s1s4m2_r, c1c4m2_r, c1s4m2_r, s5pm2_r;
  val_t txa_r, txb_r, tya_r, tyb_r, tza_r, tzb_r, s5cm3_r, s5dm3_r;
  val_t tx_r, ty_r, tz_r;

  logic signed [PROD_W-1:0] xt_r [0:4];
  logic signed [PROD_W-1:0] yt_r [0:4];
  logic signed [PROD_W-1:0] zt_r [0:4];
  logic signed [POS_W-1:0]  px_r, py_r, pz_r;

  function automatic val_t tv(input trig_t v);
    return VAL_W'(v);
  endfunction

  function automatic logic signed [PROD_W-1:0] lmul(input logic [LEN_W-1:0] l,
                                                     input val_t v);
    return PROD_W'($signed({1'b0, l})) * PROD_W'(v);
  endfunction

  function automatic logic signed [POS_W-1:0] finish(
      input logic signed [PROD_W-1:0] t0, input logic signed [PROD_W-1:0] t1,
      input logic signed [PROD_W-1:0] t2, input logic signed [PROD_W-1:0] t3,
      input logic signed [PROD_W-1:0] t4);
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] o;
    sum = SUM_W'(t0) + SUM_W'(t1) + SUM_W'(t2) + SUM_W'(t3) + SUM_W'(t4);
    o   = (sum + (SUM_W'(1) <<< (SH - 1))) >>> SH;
    if (o > SUM_W'((1 <<< (POS_W - 1)) - 1))   return {1'b0, {(POS_W-1){1'b1}}};
    else if (o < -SUM_W'(1 <<< (POS_W - 1))) return {1'b1, {(POS_W-1){1'b0}}};
    else                                      return o[POS_W-1:0];
  endfunction

  always_comb begin
    pose.s1 = sc1.sn;  pose.c1 = sc1.cs;
    pose.s2 = sc2.sn;  pose.c2 = sc2.cs;
    pose.q  = sc23.sn; pose.p  = sc23.cs;
    pose.s4 = sc4.sn;  pose.c4 = sc4.cs;
    pose.s5 = sc5.sn;  pose.c5 = sc5.cs;
    pose.s6 = sc6.sn;  pose.c6 = sc6.cs;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // level one: pairs of trig values
      pm1_r      <= pose;
      am1_r.a    <= fmul(pose.c1, tv(pose.p));
      am1_r.b    <= fmul(pose.s1, tv(pose.p));
      am1_r.c    <= fmul(pose.c1, tv(pose.q));
      am1_r.d    <= fmul(pose.s1, tv(pose.q));
      am1_r.c1c2 <= fmul(pose.c1, tv(pose.c2));
      am1_r.s1c2 <= fmul(pose.s1, tv(pose.c2));
      c4s1_r     <= fmul(pose.c4, tv(pose.s1));
      s1s4_r     <= fmul(pose.s1, tv(pose.s4));
      c1c4_r     <= fmul(pose.c1, tv(pose.c4));
      c1s4_r     <= fmul(pose.c1, tv(pose.s4));
      s4s6_r     <= fmul(pose.s4, tv(pose.s6));
      c4c5_r     <= fmul(pose.c4, tv(pose.c5));
      s5p_r      <= fmul(pose.s5, tv(pose.p));
      // level two
      pm2_r    <= pm1_r;
      am2_r    <= am1_r;
      s4a_r    <= fmul(pm1_r.s4, am1_r.a);
      c4a_r    <= fmul(pm1_r.c4, am1_r.a);
      s5c_r    <= fmul(pm1_r.s5, am1_r.c);
      s4b_r    <= fmul(pm1_r.s4, am1_r.b);
      c4b_r    <= fmul(pm1_r.c4, am1_r.b);
      s5d_r    <= fmul(pm1_r.s5, am1_r.d);
      s4s6q_r  <= fmul(pm1_r.q, s4s6_r);
      c4c5q_r  <= fmul(pm1_r.q, c4c5_r);
      c4s1m2_r <= c4s1_r;
      s1s4m2_r <= s1s4_r;
      c1c4m2_r <= c1c4_r;
      c1s4m2_r <= c1s4_r;
      s5pm2_r  <= s5p_r;
      // level three
      pm3_r   <= pm2_r;
      am3_r   <= am2_r;
      txa_r   <= fmul(pm2_r.s6, c4s1m2_r - s4a_r);
      txb_r   <= fmul(pm2_r.c5, s1s4m2_r + c4a_r);
      tya_r   <= fmul(pm2_r.s6, c1c4m2_r + s4b_r);
      tyb_r   <= fmul(pm2_r.c5, c1s4m2_r - c4b_r);
      tza_r   <= s4s6q_r;
      tzb_r   <= fmul(pm2_r.c6, s5pm2_r + c4c5q_r);
      s5cm3_r <= s5c_r;
      s5dm3_r <= s5d_r;
      // level four: tool vector
      pm4_r <= pm3_r;
      am4_r <= am3_r;
      tx_r  <= -txa_r - fmul(pm3_r.c6, txb_r - s5cm3_r);
      ty_r  <= tya_r + fmul(pm3_r.c6, tyb_r + s5dm3_r);
      tz_r  <= tza_r - tzb_r;
      // length scaling
      xt_r[0] <= lmul(geom.a, tv(pm4_r.c1));
      xt_r[1] <= lmul(geom.l, am4_r.c1c2);
      xt_r[2] <= lmul(geom.d, am4_r.a);
      xt_r[3] <= lmul(geom.f, am4_r.c);
      xt_r[4] <= lmul(geom.t, tx_r);
      yt_r[0] <= lmul(geom.a, tv(pm4_r.s1));
      yt_r[1] <= lmul(geom.l, am4_r.s1c2);
      yt_r[2] <= lmul(geom.d, am4_r.b);
      yt_r[3] <= lmul(geom.f, am4_r.d);
      yt_r[4] <= lmul(geom.t, ty_r);
      zt_r[0] <= lmul(geom.l, tv(pm4_r.s2));
      zt_r[1] <= -lmul(geom.f, tv(pm4_r.p));
      zt_r[2] <= lmul(geom.d, tv(pm4_r.q));
      zt_r[3] <= lmul(geom.h, tv(trig_t'(ONE_Q30)));
      zt_r[4] <= lmul(geom.t, tz_r);
      // sum, round, saturate
      px_r <= finish(xt_r[0], xt_r[1], xt_r[2], xt_r[3], xt_r[4]);
      py_r <= finish(yt_r[0], yt_r[1], yt_r[2], yt_r[3], yt_r[4]);
      pz_r <= finish(zt_r[0], zt_r[1], zt_r[2], zt_r[3], zt_r[4]);
    end
  end

  assign pos_x = px_r;
  assign pos_y = py_r;
  assign pos_z = pz_r;

endmodule
